[design/rmm_pkg.sv]
`default_nettype none
package rmm_pkg;

    localparam int SqrtSteps = 32;

    typedef struct packed {
        logic [63:0] num;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_state_t;

    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic [31:0]        z;
    } vec_state_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } rot_state_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] spd;
        logic signed [15:0] head;
        logic               zero;
        logic [31:0]        root;
        logic [15:0]        b16;
        logic               flip;
        logic signed [33:0] rz;
    } carry_t;

    localparam logic signed [33:0] CosGain = 34'sh026DD3B6A;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[design/rmm_sqrt_cell.sv]
`default_nettype none
module rmm_sqrt_cell (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire rmm_pkg::sqrt_state_t d_in,
    output rmm_pkg::sqrt_state_t      d_out
);
    import rmm_pkg::*;

    sqrt_state_t d_reg, d_next;
    logic [35:0] temp, trial, diff;
    logic        ge;

    always_comb begin
        temp  = {d_in.rem, d_in.num[63:62]};
        trial = {2'b00, d_in.root, 2'b01};
        diff  = temp - trial;
        ge    = temp >= trial;
        d_next.num  = {d_in.num[61:0], 2'b00};
        d_next.rem  = ge ? diff[33:0] : temp[33:0];
        d_next.root = {d_in.root[30:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule
`default_nettype wire

[design/rmm_vec_cell.sv]
`default_nettype none
module rmm_vec_cell #(
    parameter int Shift = 0
) (
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire rmm_pkg::vec_state_t d_in,
    output rmm_pkg::vec_state_t      d_out
);
    import rmm_pkg::*;

    localparam logic [31:0] Atan = atan_turn(5'(Shift));

    vec_state_t d_reg, d_next;
    logic signed [35:0] xs, ys;

    always_comb begin
        xs = d_in.x >>> Shift;
        ys = d_in.y >>> Shift;
        if (!d_in.y[35]) begin
            d_next.x = d_in.x + ys;
            d_next.y = d_in.y - xs;
            d_next.z = d_in.z + Atan;
        end else begin
            d_next.x = d_in.x - ys;
            d_next.y = d_in.y + xs;
            d_next.z = d_in.z - Atan;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule
`default_nettype wire

[design/rmm_rot_cell.sv]
`default_nettype none
module rmm_rot_cell #(
    parameter int Shift = 0
) (
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire rmm_pkg::rot_state_t d_in,
    output rmm_pkg::rot_state_t      d_out
);
    import rmm_pkg::*;

    localparam logic signed [33:0] Atan = $signed({2'b00, atan_turn(5'(Shift))});

    rot_state_t d_reg, d_next;
    logic signed [33:0] xs, ys;

    always_comb begin
        xs = d_in.x >>> Shift;
        ys = d_in.y >>> Shift;
        if (!d_in.z[33]) begin
            d_next.x = d_in.x - ys;
            d_next.y = d_in.y + xs;
            d_next.z = d_in.z - Atan;
        end else begin
            d_next.x = d_in.x + ys;
            d_next.y = d_in.y - xs;
            d_next.z = d_in.z + Atan;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule
`default_nettype wire

[design/radar_measurement_model_unit.sv]
`default_nettype none
// Throughput: one word per cycle when not stalled; every square-root step and CORDIC stage is its own cell.
// The whole chain advances together whenever the output register is empty or taken.
// Reset (aresetn low, synchronous) clears the valid flags of every cell and of the output.
module radar_measurement_model_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [111:0] s_tdata,  // pos_x, pos_y, speed, heading
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [79:0]       m_tdata,  // range, bearing, range_rate
    output logic              m_tuser   // zero_range
);
    import rmm_pkg::*;

    localparam int PosSqEnd = 2 + SqrtSteps;
    localparam int PosVecEnd = PosSqEnd + CORDIC_STAGES;
    localparam int PosDelta = PosVecEnd + 1;
    localparam int PosRotEnd = PosDelta + CORDIC_STAGES;
    localparam int PosProd = PosRotEnd + 1;

    logic   adv;
    logic   vld_reg [0:PosProd];
    carry_t carry_reg [0:PosProd];
    carry_t carry_next [1:PosProd];
    logic [63:0] ax2_reg, ay2_reg;
    logic [31:0] ax, ay;

    sqrt_state_t sq_in [0:SqrtSteps-1];
    sqrt_state_t sq_out [0:SqrtSteps-1];
    vec_state_t  vc_in [0:CORDIC_STAGES-1];
    vec_state_t  vc_out [0:CORDIC_STAGES-1];
    rot_state_t  rc_in [0:CORDIC_STAGES-1];
    rot_state_t  rc_out [0:CORDIC_STAGES-1];

    logic signed [34:0] c_val;
    logic signed [66:0] prod_reg, prod_next, rnd;
    logic signed [31:0] rr_sat;
    logic               m_tvalid_reg;
    logic [79:0]        m_tdata_reg;
    logic               m_tuser_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p <= PosProd; p++) begin
                vld_reg[p] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
            for (int p = 1; p <= PosProd; p++) begin
                vld_reg[p] <= vld_reg[p-1];
            end
            m_tvalid_reg <= vld_reg[PosProd];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            carry_reg[0].px   <= $signed(s_tdata[31:0]);
            carry_reg[0].py   <= $signed(s_tdata[63:32]);
            carry_reg[0].spd  <= $signed(s_tdata[95:64]);
            carry_reg[0].head <= $signed(s_tdata[111:96]);
            carry_reg[0].zero <= (s_tdata[63:0] == 64'd0);
            carry_reg[0].root <= '0;
            carry_reg[0].b16  <= '0;
            carry_reg[0].flip <= 1'b0;
            carry_reg[0].rz   <= '0;
            for (int p = 1; p <= PosProd; p++) begin
                carry_reg[p] <= carry_next[p];
            end
        end
    end

    genvar gp;
    generate
        for (gp = 1; gp <= PosProd; gp++) begin : g_carry
            if (gp == PosSqEnd + 1) begin : g_root
                always_comb begin
                    carry_next[gp]      = carry_reg[gp-1];
                    carry_next[gp].root = sq_out[SqrtSteps-1].root;
                end
            end else if (gp == PosDelta) begin : g_delta
                logic [31:0] zr;
                logic [15:0] b16, delta, dsum, ud;
                always_comb begin
                    zr    = vc_out[CORDIC_STAGES-1].z + 32'h0000_8000;
                    b16   = zr[31:16];
                    delta = carry_reg[gp-1].head - b16;
                    dsum  = delta + 16'h4000;
                    ud    = dsum[15] ? (delta ^ 16'h8000) : delta;
                    carry_next[gp]      = carry_reg[gp-1];
                    carry_next[gp].b16  = b16;
                    carry_next[gp].flip = dsum[15];
                    carry_next[gp].rz   = $signed({{2{ud[15]}}, ud, 16'h0000});
                end
            end else begin : g_pass
                assign carry_next[gp] = carry_reg[gp-1];
            end
        end
    endgenerate

    assign ax = carry_reg[0].px[31] ? 32'(-carry_reg[0].px) : carry_reg[0].px;
    assign ay = carry_reg[0].py[31] ? 32'(-carry_reg[0].py) : carry_reg[0].py;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ax2_reg <= 64'(ax) * 64'(ax);
            ay2_reg <= 64'(ay) * 64'(ay);
        end
    end

    sqrt_state_t sum_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg.num  <= ax2_reg + ay2_reg;
            sum_reg.rem  <= '0;
            sum_reg.root <= '0;
        end
    end

    genvar gk;
    generate
        for (gk = 0; gk < SqrtSteps; gk++) begin : g_sqrt
            if (gk == 0) begin : g_first
                assign sq_in[gk] = sum_reg;
            end else begin : g_next
                assign sq_in[gk] = sq_out[gk-1];
            end
            rmm_sqrt_cell u_cell (
                .aclk  (aclk),
                .en    (adv),
                .d_in  (sq_in[gk]),
                .d_out (sq_out[gk])
            );
        end

        for (gk = 0; gk < CORDIC_STAGES; gk++) begin : g_vec
            if (gk == 0) begin : g_first
                logic signed [35:0] px36, py36;
                always_comb begin
                    px36 = 36'(carry_reg[PosSqEnd].px);
                    py36 = 36'(carry_reg[PosSqEnd].py);
                    if (carry_reg[PosSqEnd].px[31]) begin
                        vc_in[gk].x = -px36;
                        vc_in[gk].y = -py36;
                        vc_in[gk].z = 32'h8000_0000;
                    end else begin
                        vc_in[gk].x = px36;
                        vc_in[gk].y = py36;
                        vc_in[gk].z = 32'h0000_0000;
                    end
                end
            end else begin : g_next
                assign vc_in[gk] = vc_out[gk-1];
            end
            rmm_vec_cell #(.Shift(gk)) u_cell (
                .aclk  (aclk),
                .en    (adv),
                .d_in  (vc_in[gk]),
                .d_out (vc_out[gk])
            );
        end

        for (gk = 0; gk < CORDIC_STAGES; gk++) begin : g_rot
            if (gk == 0) begin : g_first
                always_comb begin
                    rc_in[gk].x = CosGain;
                    rc_in[gk].y = '0;
                    rc_in[gk].z = carry_reg[PosDelta].rz;
                end
            end else begin : g_next
                assign rc_in[gk] = rc_out[gk-1];
            end
            rmm_rot_cell #(.Shift(gk)) u_cell (
                .aclk  (aclk),
                .en    (adv),
                .d_in  (rc_in[gk]),
                .d_out (rc_out[gk])
            );
        end
    endgenerate

    always_comb begin
        c_val = 35'(rc_out[CORDIC_STAGES-1].x);
        if (carry_reg[PosRotEnd].flip) begin
            c_val = -c_val;
        end
        prod_next = 67'(carry_reg[PosRotEnd].spd) * 67'(c_val);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
        end
    end

    always_comb begin
        rnd = (prod_reg + 67'sd536870912) >>> 30;
        if (rnd > 67'sd2147483647) begin
            rr_sat = 32'sh7FFF_FFFF;
        end else if (rnd < -67'sd2147483648) begin
            rr_sat = 32'sh8000_0000;
        end else begin
            rr_sat = rnd[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tuser_reg <= carry_reg[PosProd].zero;
            if (carry_reg[PosProd].zero) begin
                m_tdata_reg <= '0;
            end else begin
                m_tdata_reg <= {rr_sat, carry_reg[PosProd].b16, carry_reg[PosProd].root};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    a_zero_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 80'd0)
        else $error("zero range word carries nonzero data");
    a_range_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[31:0] != 32'd0)
        else $error("nonzero position gave zero range");
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word did not enter the chain");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> vld_reg[PosProd] == $past(vld_reg[PosProd]))
        else $error("chain moved while stalled");
`endif

endmodule
`default_nettype wire

[sim/tb_radar_measurement_model_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_radar_measurement_model_unit;

    localparam int Stages = 16;
    localparam int Latency = 2 * Stages + 37;
    localparam longint CycleLimit = 400000;
    localparam int RandomWords = 1500;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] spd;
        logic signed [15:0] head;
    } state_word_t;

    typedef struct {
        logic [31:0]        range_q;
        logic [15:0]        bearing;
        logic signed [31:0] rate;
        logic               zero_range;
    } radar_word_t;

    typedef struct {
        state_word_t stim;
        logic        given;
        radar_word_t want;
    } directed_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;
    logic         m_tuser;

    radar_word_t  radar_queue[$];
    int           fails;
    longint       cycles;
    int           send_idle_pct;
    int           recv_stall_pct;

    radar_measurement_model_unit #(.CORDIC_STAGES(Stages)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [31:0] arctan_step(input int i);
        logic [31:0] t[32];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
              32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
              32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
              32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
              32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
              32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
              32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
        return t[i];
    endfunction

    function automatic radar_word_t radar_view(input state_word_t s);
        radar_word_t r;
        longint x, y, xs, ys, c, z, rr;
        logic [63:0] sq, root, bit_w;
        logic [31:0] ang, u;
        logic [15:0] delta;
        logic flip;
        int n;
        n = (Stages > 32) ? 32 : Stages;
        x = s.px;
        y = s.py;
        sq = 64'(x * x) + 64'(y * y);
        root = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > sq) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (sq >= root + bit_w) begin
                sq = sq - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        r = '{default: '0};
        if (root == 0) begin
            r.zero_range = 1'b1;
            return r;
        end
        ang = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = 32'h80000000;
        end
        for (int i = 0; i < n; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                ang = ang + arctan_step(i);
            end else begin
                x = x - ys;
                y = y + xs;
                ang = ang - arctan_step(i);
            end
        end
        r.bearing = 16'((ang + 32'h8000) >> 16);
        delta = 16'(s.head) - r.bearing;
        u = {delta, 16'h0};
        flip = 1'b0;
        if (((u + 32'h40000000) & 32'h80000000) != 0) begin
            flip = 1'b1;
            u = u + 32'h80000000;
        end
        z = longint'(signed'(u));
        x = 64'h26DD3B6A;
        y = 0;
        for (int i = 0; i < n; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(arctan_step(i));
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(arctan_step(i));
            end
        end
        c = flip ? -x : x;
        rr = (longint'(s.spd) * c + (64'sd1 <<< 29)) >>> 30;
        if (rr > 64'sd2147483647) rr = 64'sd2147483647;
        if (rr < -64'sd2147483648) rr = -64'sd2147483648;
        r.range_q = root[31:0];
        r.rate = rr[31:0];
        return r;
    endfunction

    task automatic send_word(input state_word_t s);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= {s.head, s.spd, s.py, s.px};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        radar_queue.push_back(radar_view(s));
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (radar_queue.size() != 0) @(negedge aclk);
        repeat (Latency + 5) @(negedge aclk);
    endtask

    function automatic state_word_t random_state;
        state_word_t s;
        int shape;
        shape = $urandom_range(5);
        s.px = $urandom;
        s.py = $urandom;
        s.spd = $urandom;
        s.head = 16'($urandom);
        case (shape)
            0: begin
                s.px = $signed(s.px) >>> $urandom_range(31);
                s.py = $signed(s.py) >>> $urandom_range(31);
            end
            1: s.px = $urandom_range(1) ? 32'sd0 : s.px;
            2: s.py = $urandom_range(1) ? 32'sd0 : s.py;
            3: begin
                s.px = $urandom_range(3) - 2;
                s.py = $urandom_range(3) - 2;
            end
            default: ;
        endcase
        return s;
    endfunction

    always @(posedge aclk) begin
        radar_word_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.range_q = m_tdata[31:0];
            got.bearing = m_tdata[47:32];
            got.rate = m_tdata[79:48];
            got.zero_range = m_tuser;
            if (radar_queue.size() == 0) begin
                $error("unexpected word: range %h", got.range_q);
                fails++;
            end else begin
                want = radar_queue.pop_front();
                if (got.range_q !== want.range_q) begin
                    $error("range exp %h got %h", want.range_q, got.range_q);
                    fails++;
                end
                if (got.bearing !== want.bearing) begin
                    $error("bearing exp %h got %h", want.bearing, got.bearing);
                    fails++;
                end
                if (got.rate !== want.rate) begin
                    $error("range_rate exp %h got %h", want.rate, got.rate);
                    fails++;
                end
                if (got.zero_range !== want.zero_range) begin
                    $error("zero_range exp %b got %b", want.zero_range, got.zero_range);
                    fails++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= !aresetn ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    directed_row_t rows[$];

    initial begin
        state_word_t s;
        radar_word_t z0;
        fails = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        z0 = '{range_q: 32'd0, bearing: 16'd0, rate: 32'sd0, zero_range: 1'b1};
        // zero range, with every speed and heading extreme, then extreme and axis positions
        rows.push_back('{'{0, 0, 0, 16'h0000}, 1'b1, z0});
        rows.push_back('{'{0, 0, 32'h7FFFFFFF, 16'h7FFF}, 1'b1, z0});
        rows.push_back('{'{0, 0, 32'h80000000, 16'h8000}, 1'b1, z0});
        rows.push_back('{'{0, 0, -1, 16'hFFFF}, 1'b1, z0});
        rows.push_back('{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h2000}, 1'b0, z0});
        rows.push_back('{'{32'h80000000, 32'h80000000, 32'h80000000, 16'h8000}, 1'b0, z0});
        rows.push_back('{'{32'h80000000, 0, 32'h7FFFFFFF, 16'h8000}, 1'b0, z0});
        rows.push_back('{'{32'h80000000, 1, 32'h80000000, 16'h0000}, 1'b0, z0});
        rows.push_back('{'{32'h80000000, -1, 32'h00010000, 16'h0000}, 1'b0, z0});
        rows.push_back('{'{0, 32'h80000000, 32'h7FFFFFFF, 16'h4000}, 1'b0, z0});
        rows.push_back('{'{1, 0, 32'h00010000, 16'h0000}, 1'b0, z0});
        rows.push_back('{'{-1, 0, 32'h00010000, 16'h8000}, 1'b0, z0});
        rows.push_back('{'{0, 1, 32'h00010000, 16'h4000}, 1'b0, z0});
        rows.push_back('{'{0, -1, 32'h00010000, 16'hC000}, 1'b0, z0});
        rows.push_back('{'{32'h00010000, 0, 32'h00010000, 16'h4001}, 1'b0, z0});
        rows.push_back('{'{32'h00010000, 0, 32'h00010000, 16'hBFFF}, 1'b0, z0});
        rows.push_back('{'{32'h00010000, 32'h00010000, 32'hFFFF0000, 16'h6000}, 1'b0, z0});
        rows.push_back('{'{32'hFFFF0000, 32'h00010000, 32'h7FFFFFFF, 16'h6000}, 1'b0, z0});
        rows.push_back('{'{32'h7FFFFFFF, 0, 32'h7FFFFFFF, 16'h0000}, 1'b0, z0});
        rows.push_back('{'{32'h7FFFFFFF, 0, 32'h80000000, 16'h0000}, 1'b0, z0});
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (rows[i]) begin
            send_word(rows[i].stim);
            if (rows[i].given) radar_queue[$] = rows[i].want;
        end
        drain();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            for (int k = 0; k < RandomWords / 4; k++) begin
                s = random_state();
                send_word(s);
            end
            drain();
        end
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
